// ===== hw/rtl/like_sign_background_subtract_macros.svh =====
// Assertion macros for the checker file of the background subtractor.
`ifndef LIKE_SIGN_BACKGROUND_SUBTRACT_MACROS_SVH
`define LIKE_SIGN_BACKGROUND_SUBTRACT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define LSBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, switched off while reset is held.
`define LSBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/lsbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbs_pkg
// Types and fixed constants of the like-sign background subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsbs_pkg;

    // Left shift that forms 4*a*e^2 before the ratio division.
    localparam int RATIO_SHIFT = 2;
    // Left shift that forms 16*P*N under the background root.
    localparam int BG_SHIFT    = 4;

    // Per-item control flags carried down the pipeline.
    typedef struct packed {
        logic pass;   // P or N is zero: inputs are copied out
        logic uzero;  // unlike count is zero: error result is zero
    } t_flags;

endpackage

`default_nettype wire

// ===== hw/rtl/lsbs_front.sv =====
// ----------------------------------------------------------------------------
// lsbs_front
// Three multiplier stages that build the division numerators and 16*P*N.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsbs_front #(
    parameter int IN_W = 32,
    localparam int NUM_W = 3 * IN_W + lsbs_pkg::RATIO_SHIFT,
    localparam int PN_W  = 2 * IN_W + lsbs_pkg::BG_SHIFT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic                  i_valid,
    input  wire logic [IN_W-1:0]       i_u,
    input  wire logic [IN_W-1:0]       i_p,
    input  wire logic [IN_W-1:0]       i_n,
    input  wire logic [IN_W-1:0]       i_eu,
    input  wire logic [IN_W-1:0]       i_ep,
    input  wire logic [IN_W-1:0]       i_en,
    output logic                       o_valid,
    output logic [NUM_W-1:0]           o_num_p,
    output logic [NUM_W-1:0]           o_num_n,
    output logic [IN_W-1:0]            o_p,
    output logic [IN_W-1:0]            o_n,
    output logic [IN_W-1:0]            o_u,
    output logic [IN_W-1:0]            o_eu,
    output logic [2*IN_W-1:0]          o_eu2,
    output logic [PN_W-1:0]            o_pn16,
    output lsbs_pkg::t_flags           o_flags
);
    import lsbs_pkg::*;

    localparam int P_W = 2 * IN_W;

    // Stage A: squares and the P*N product.
    logic [P_W-1:0]  n_a_eu2, n_a_ep2, n_a_en2, n_a_pn;
    t_flags          n_a_flags;
    logic            r_a_v;
    logic [P_W-1:0]  r_a_eu2, r_a_ep2, r_a_en2, r_a_pn;
    logic [IN_W-1:0] r_a_u, r_a_p, r_a_n, r_a_eu;
    t_flags          r_a_flags;

    assign n_a_eu2 = P_W'(i_eu) * P_W'(i_eu);
    assign n_a_ep2 = P_W'(i_ep) * P_W'(i_ep);
    assign n_a_en2 = P_W'(i_en) * P_W'(i_en);
    assign n_a_pn  = P_W'(i_p) * P_W'(i_n);
    assign n_a_flags.pass  = (i_p == '0) || (i_n == '0);
    assign n_a_flags.uzero = (i_u == '0);

    // Stage B: the squared errors times the opposite count, in two halves.
    logic [P_W-1:0]  n_b_pe_lo, n_b_pe_hi, n_b_ne_lo, n_b_ne_hi;
    logic            r_b_v;
    logic [P_W-1:0]  r_b_pe_lo, r_b_pe_hi, r_b_ne_lo, r_b_ne_hi;
    logic [P_W-1:0]  r_b_eu2, r_b_pn;
    logic [IN_W-1:0] r_b_u, r_b_p, r_b_n, r_b_eu;
    t_flags          r_b_flags;

    assign n_b_pe_lo = P_W'(r_a_n) * P_W'(r_a_ep2[IN_W-1:0]);
    assign n_b_pe_hi = P_W'(r_a_n) * P_W'(r_a_ep2[P_W-1:IN_W]);
    assign n_b_ne_lo = P_W'(r_a_p) * P_W'(r_a_en2[IN_W-1:0]);
    assign n_b_ne_hi = P_W'(r_a_p) * P_W'(r_a_en2[P_W-1:IN_W]);

    // Stage C: join the halves and scale by four, scale P*N by sixteen.
    logic [NUM_W-1:0] n_c_num_p, n_c_num_n;
    logic [PN_W-1:0]  n_c_pn16;
    logic             r_c_v;

    assign n_c_num_p = (NUM_W'(r_b_pe_hi) << (IN_W + RATIO_SHIFT))
                     + (NUM_W'(r_b_pe_lo) << RATIO_SHIFT);
    assign n_c_num_n = (NUM_W'(r_b_ne_hi) << (IN_W + RATIO_SHIFT))
                     + (NUM_W'(r_b_ne_lo) << RATIO_SHIFT);
    assign n_c_pn16  = PN_W'(r_b_pn) << BG_SHIFT;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_adv) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_eu2   <= n_a_eu2;
            r_a_ep2   <= n_a_ep2;
            r_a_en2   <= n_a_en2;
            r_a_pn    <= n_a_pn;
            r_a_u     <= i_u;
            r_a_p     <= i_p;
            r_a_n     <= i_n;
            r_a_eu    <= i_eu;
            r_a_flags <= n_a_flags;

            r_b_pe_lo <= n_b_pe_lo;
            r_b_pe_hi <= n_b_pe_hi;
            r_b_ne_lo <= n_b_ne_lo;
            r_b_ne_hi <= n_b_ne_hi;
            r_b_eu2   <= r_a_eu2;
            r_b_pn    <= r_a_pn;
            r_b_u     <= r_a_u;
            r_b_p     <= r_a_p;
            r_b_n     <= r_a_n;
            r_b_eu    <= r_a_eu;
            r_b_flags <= r_a_flags;

            o_num_p   <= n_c_num_p;
            o_num_n   <= n_c_num_n;
            o_pn16    <= n_c_pn16;
            o_p       <= r_b_p;
            o_n       <= r_b_n;
            o_u       <= r_b_u;
            o_eu      <= r_b_eu;
            o_eu2     <= r_b_eu2;
            o_flags   <= r_b_flags;
        end
    end

    assign o_valid = r_c_v;

endmodule

`default_nettype wire

// ===== hw/rtl/lsbs_div2.sv =====
// ----------------------------------------------------------------------------
// lsbs_div2
// Two restoring dividers side by side, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsbs_div2 #(
    parameter int NUM_W  = 98,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [1:0][NUM_W-1:0]       i_num,
    input  wire logic [1:0][DEN_W-1:0]       i_den,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    output logic [1:0][NUM_W-1:0]            o_quo,
    output logic [SIDE_W-1:0]                o_side
);

    // Each stage holds the numerator bits still to go, shifted up, with the
    // quotient bits filling in from the bottom, and the partial remainder.
    logic [NUM_W-1:0]               r_v;
    logic [1:0][NUM_W-1:0]          r_nq   [NUM_W];
    logic [1:0][DEN_W-1:0]          r_rem  [NUM_W];
    logic [1:0][DEN_W-1:0]          r_den  [NUM_W];
    logic [SIDE_W-1:0]              r_side [NUM_W];
    logic [1:0][NUM_W-1:0]          n_nq   [NUM_W];
    logic [1:0][DEN_W-1:0]          n_rem  [NUM_W];
    logic [1:0][DEN_W-1:0]          n_den  [NUM_W];
    logic [SIDE_W-1:0]              n_side [NUM_W];

    // One compare and subtract per stage and lane.
    always_comb begin
        logic [NUM_W-1:0] v_nq;
        logic [DEN_W-1:0] v_rem;
        logic [DEN_W-1:0] v_den;
        logic [DEN_W:0]   v_trial;
        logic [DEN_W:0]   v_diff;
        logic             v_ge;
        int               v_idx;
        for (int s = 0; s < NUM_W; s++) begin
            v_idx     = (s > 0) ? s - 1 : 0;
            n_side[s] = (s == 0) ? i_side : r_side[v_idx];
            for (int l = 0; l < 2; l++) begin
                if (s == 0) begin
                    v_nq  = i_num[l];
                    v_rem = '0;
                    v_den = i_den[l];
                end else begin
                    v_nq  = r_nq[v_idx][l];
                    v_rem = r_rem[v_idx][l];
                    v_den = r_den[v_idx][l];
                end
                v_trial = {v_rem, v_nq[NUM_W-1]};
                v_diff  = v_trial - {1'b0, v_den};
                v_ge    = (v_trial >= {1'b0, v_den});
                n_rem[s][l] = v_ge ? v_diff[DEN_W-1:0] : v_trial[DEN_W-1:0];
                n_nq[s][l]  = {v_nq[NUM_W-2:0], v_ge};
                n_den[s][l] = v_den;
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NUM_W-2:0], i_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_nq[s]   <= n_nq[s];
                r_rem[s]  <= n_rem[s];
                r_den[s]  <= n_den[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/lsbs_sqrt2.sv =====
// ----------------------------------------------------------------------------
// lsbs_sqrt2
// Two digit-by-digit integer square roots, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsbs_sqrt2 #(
    parameter int SQ_W   = 100,
    parameter int SIDE_W = 8,
    localparam int ROOT_W = SQ_W / 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_valid,
    input  wire logic [1:0][SQ_W-1:0]       i_rad,
    input  wire logic [SIDE_W-1:0]          i_side,
    output logic                            o_valid,
    output logic [1:0][ROOT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int REM_W = ROOT_W + 2;

    logic [ROOT_W-1:0]             r_v;
    logic [1:0][SQ_W-1:0]          r_x    [ROOT_W];
    logic [1:0][ROOT_W-1:0]        r_root [ROOT_W];
    logic [1:0][REM_W-1:0]         r_rem  [ROOT_W];
    logic [SIDE_W-1:0]             r_side [ROOT_W];
    logic [1:0][SQ_W-1:0]          n_x    [ROOT_W];
    logic [1:0][ROOT_W-1:0]        n_root [ROOT_W];
    logic [1:0][REM_W-1:0]         n_rem  [ROOT_W];
    logic [SIDE_W-1:0]             n_side [ROOT_W];

    // Bring down two radicand bits, try 4*root+1 against the remainder.
    always_comb begin
        logic [SQ_W-1:0]    v_x;
        logic [ROOT_W-1:0]  v_root;
        logic [REM_W-1:0]   v_rem;
        logic [REM_W+1:0]   v_cat;
        logic [REM_W+1:0]   v_trial;
        logic [REM_W+1:0]   v_diff;
        logic               v_ge;
        int                 v_idx;
        for (int s = 0; s < ROOT_W; s++) begin
            v_idx     = (s > 0) ? s - 1 : 0;
            n_side[s] = (s == 0) ? i_side : r_side[v_idx];
            for (int l = 0; l < 2; l++) begin
                if (s == 0) begin
                    v_x    = i_rad[l];
                    v_root = '0;
                    v_rem  = '0;
                end else begin
                    v_x    = r_x[v_idx][l];
                    v_root = r_root[v_idx][l];
                    v_rem  = r_rem[v_idx][l];
                end
                v_cat   = {v_rem, v_x[SQ_W-1:SQ_W-2]};
                v_trial = (REM_W + 2)'({v_root, 2'b01});
                v_diff  = v_cat - v_trial;
                v_ge    = (v_cat >= v_trial);
                n_rem[s][l]  = v_ge ? v_diff[REM_W-1:0] : v_cat[REM_W-1:0];
                n_root[s][l] = {v_root[ROOT_W-2:0], v_ge};
                n_x[s][l]    = {v_x[SQ_W-3:0], 2'b00};
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < ROOT_W; s++) begin
                r_x[s]    <= n_x[s];
                r_root[s] <= n_root[s];
                r_rem[s]  <= n_rem[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/like_sign_background_subtract.sv =====
// ----------------------------------------------------------------------------
// like_sign_background_subtract
// Per-bin like-sign background subtraction with error propagation.
// ----------------------------------------------------------------------------
//   channel   direction   handshake            payload
//   input     in          i_valid / o_stall    i_count_*, i_error_*
//   output    out         o_valid / i_stall    o_sub_count, o_sub_error, flags
//
// One bin enters per cycle while o_stall is low; the dividers and square
// roots inside work one bit per stage.
// Reset clears only the valid bits; there is no clearing pass.
// The whole pipeline holds while a result waits under i_stall, so o_stall
// is raised only in that case and no bin is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module like_sign_background_subtract #(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [INT_BITS+FRAC_BITS-1:0]          i_count_unlike,
    input  wire logic [INT_BITS+FRAC_BITS-1:0]          i_count_pos,
    input  wire logic [INT_BITS+FRAC_BITS-1:0]          i_count_neg,
    input  wire logic [INT_BITS+FRAC_BITS-1:0]          i_error_unlike,
    input  wire logic [INT_BITS+FRAC_BITS-1:0]          i_error_pos,
    input  wire logic [INT_BITS+FRAC_BITS-1:0]          i_error_neg,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [INT_BITS+FRAC_BITS+3:0]        o_sub_count,
    output logic [INT_BITS+FRAC_BITS+3:0]               o_sub_error,
    output logic                                        o_passed_through,
    output logic                                        o_saturated
);
    import lsbs_pkg::*;

    localparam int IN_W    = INT_BITS + FRAC_BITS;
    localparam int OUT_W   = IN_W + 4;
    localparam int NUM_W   = 3 * IN_W + RATIO_SHIFT;
    localparam int PN_W    = 2 * IN_W + BG_SHIFT;
    localparam int SQ_W    = ((NUM_W + 2) / 2) * 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int FL_W    = $bits(t_flags);
    localparam int DSIDE_W = 2 * IN_W + 2 * IN_W + PN_W + FL_W;
    localparam int QSIDE_W = 2 * IN_W + FL_W;

    // Global advance: every stage moves unless a result waits under stall.
    logic w_adv;
    logic r_o_v;

    assign w_adv   = !r_o_v || !i_stall;
    assign o_stall = !w_adv;

    // Multiplier front end.
    logic              f_v;
    logic [NUM_W-1:0]  f_num_p, f_num_n;
    logic [IN_W-1:0]   f_p, f_n, f_u, f_eu;
    logic [2*IN_W-1:0] f_eu2;
    logic [PN_W-1:0]   f_pn16;
    t_flags            f_flags;

    lsbs_front #(.IN_W(IN_W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_u     (i_count_unlike),
        .i_p     (i_count_pos),
        .i_n     (i_count_neg),
        .i_eu    (i_error_unlike),
        .i_ep    (i_error_pos),
        .i_en    (i_error_neg),
        .o_valid (f_v),
        .o_num_p (f_num_p),
        .o_num_n (f_num_n),
        .o_p     (f_p),
        .o_n     (f_n),
        .o_u     (f_u),
        .o_eu    (f_eu),
        .o_eu2   (f_eu2),
        .o_pn16  (f_pn16),
        .o_flags (f_flags)
    );

    // Ratio divisions: 4*N*eP^2 / P and 4*P*eN^2 / N.
    logic                  d_v;
    logic [1:0][NUM_W-1:0] d_quo;
    logic [DSIDE_W-1:0]    d_side;
    logic [IN_W-1:0]       d_u, d_eu;
    logic [2*IN_W-1:0]     d_eu2;
    logic [PN_W-1:0]       d_pn16;
    t_flags                d_flags;

    lsbs_div2 #(.NUM_W(NUM_W), .DEN_W(IN_W), .SIDE_W(DSIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (f_v),
        .i_num   ({f_num_n, f_num_p}),
        .i_den   ({f_n, f_p}),
        .i_side  ({f_u, f_eu, f_eu2, f_pn16, f_flags}),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    assign {d_u, d_eu, d_eu2, d_pn16, d_flags} = d_side;

    // Sum of the three variance terms; pad the background radicand.
    logic            r_s_v;
    logic [SQ_W-1:0] r_s_sum, r_s_bg;
    logic [IN_W-1:0] r_s_u, r_s_eu;
    t_flags          r_s_flags;
    logic [SQ_W-1:0] n_s_sum;

    assign n_s_sum = SQ_W'(d_eu2) + SQ_W'(d_quo[0]) + SQ_W'(d_quo[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (w_adv) begin
            r_s_v <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_sum   <= n_s_sum;
            r_s_bg    <= SQ_W'(d_pn16);
            r_s_u     <= d_u;
            r_s_eu    <= d_eu;
            r_s_flags <= d_flags;
        end
    end

    // Square roots of the variance and of 16*P*N.
    logic                   q_v;
    logic [1:0][ROOT_W-1:0] q_root;
    logic [QSIDE_W-1:0]     q_side;
    logic [IN_W-1:0]        q_u, q_eu;
    t_flags                 q_flags;

    lsbs_sqrt2 #(.SQ_W(SQ_W), .SIDE_W(QSIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_s_v),
        .i_rad   ({r_s_bg, r_s_sum}),
        .i_side  ({r_s_u, r_s_eu, r_s_flags}),
        .o_valid (q_v),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    assign {q_u, q_eu, q_flags} = q_side;

    // Result selection: pass-through, zero unlike count, or clamped error.
    logic [OUT_W-1:0] n_o_count, n_o_error;
    logic             n_o_pass, n_o_sat;
    logic             w_over;

    assign w_over = |q_root[0][ROOT_W-1:OUT_W];

    always_comb begin
        n_o_count = OUT_W'(q_u) - OUT_W'(q_root[1]);
        n_o_pass  = 1'b0;
        n_o_sat   = 1'b0;
        n_o_error = q_root[0][OUT_W-1:0];
        if (q_flags.pass) begin
            n_o_count = OUT_W'(q_u);
            n_o_error = OUT_W'(q_eu);
            n_o_pass  = 1'b1;
        end else if (q_flags.uzero) begin
            n_o_error = '0;
        end else if (w_over) begin
            n_o_error = '1;
            n_o_sat   = 1'b1;
        end
    end

    // Output register.
    logic [OUT_W-1:0] r_o_count, r_o_error;
    logic             r_o_pass, r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_adv) begin
            r_o_v <= q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_count <= n_o_count;
            r_o_error <= n_o_error;
            r_o_pass  <= n_o_pass;
            r_o_sat   <= n_o_sat;
        end
    end

    assign o_valid          = r_o_v;
    assign o_sub_count      = signed'(r_o_count);
    assign o_sub_error      = r_o_error;
    assign o_passed_through = r_o_pass;
    assign o_saturated      = r_o_sat;

endmodule

`default_nettype wire

// ===== hw/rtl/lsbs_checker.sv =====
// ----------------------------------------------------------------------------
// lsbs_checker
// Port-level checks on the background subtractor, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "like_sign_background_subtract_macros.svh"

module lsbs_checker #(
    parameter int OUT_W = 36
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             o_stall,
    input  wire logic             o_valid,
    input  wire logic             i_stall,
    input  wire logic [OUT_W-1:0] o_sub_error,
    input  wire logic             o_passed_through,
    input  wire logic             o_saturated
);

    // The input side stalls only behind a result that is itself stalled.
    `LSBS_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // A stalled result is still offered in the next cycle.
    `LSBS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // A copied bin never reports a clamped error.
    `LSBS_ASSERT_IMP(a_pass_no_sat, i_clk, i_rst_n, o_valid && o_passed_through, !o_saturated)

    // A clamped error sits at full scale.
    `LSBS_ASSERT_IMP(a_sat_max, i_clk, i_rst_n, o_valid && o_saturated, o_sub_error == {OUT_W{1'b1}})

endmodule

bind like_sign_background_subtract lsbs_checker #(
    .OUT_W(INT_BITS + FRAC_BITS + 4)
) u_lsbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_sub_error      (o_sub_error),
    .o_passed_through (o_passed_through),
    .o_saturated      (o_saturated)
);

`default_nettype wire

// ===== test/like_sign_background_subtract_test.sv =====
// ----------------------------------------------------------------------------
// like_sign_background_subtract_test
// Self-checking bench for the like-sign background subtractor. A short table
// of directed bins is applied first: zero and full-scale fields, pass-through,
// zero unlike count and error saturation. A few hundred random bins follow.
// Each accepted bin is predicted with exact wide integer arithmetic and is
// queued. Each result transfer is then compared field by field with the
// oldest queued prediction. Random gaps on the sender side and random stalls
// on the receiver side exercise the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module like_sign_background_subtract_test;

    localparam int IN_W      = 32;
    localparam int OUT_W     = IN_W + 4;
    localparam int N_RANDOM  = 480;
    localparam int DRAIN     = 200;
    localparam logic [OUT_W-1:0] ERR_MAX = '1;

    typedef struct packed {
        logic signed [OUT_W-1:0] sub_count;
        logic [OUT_W-1:0]        sub_error;
        logic                    passed;
        logic                    sat;
    } t_bin_result;

    typedef struct {
        logic [IN_W-1:0] u, p, n, eu, ep, en;
        bit              typed;
        t_bin_result     res;
    } t_bin_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [IN_W-1:0]   i_count_unlike = '0;
    logic [IN_W-1:0]   i_count_pos = '0;
    logic [IN_W-1:0]   i_count_neg = '0;
    logic [IN_W-1:0]   i_error_unlike = '0;
    logic [IN_W-1:0]   i_error_pos = '0;
    logic [IN_W-1:0]   i_error_neg = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_sub_count;
    logic [OUT_W-1:0]  o_sub_error;
    logic              o_passed_through;
    logic              o_saturated;

    t_bin_result       pending_bins[$];
    int                mismatches = 0;
    bit                calm = 1'b0;

    like_sign_background_subtract i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_count_unlike   (i_count_unlike),
        .i_count_pos      (i_count_pos),
        .i_count_neg      (i_count_neg),
        .i_error_unlike   (i_error_unlike),
        .i_error_pos      (i_error_pos),
        .i_error_neg      (i_error_neg),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sub_count      (o_sub_count),
        .o_sub_error      (o_sub_error),
        .o_passed_through (o_passed_through),
        .o_saturated      (o_saturated)
    );

    always #10 i_clk = ~i_clk;

    // Floor of the square root, one result bit per pass.
    function automatic logic [63:0] root_floor(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  trial;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= x) begin
                r = trial;
            end
        end
        return r;
    endfunction

    // Background-subtracted count and propagated error of one bin.
    function automatic t_bin_result subtract_bin(logic [IN_W-1:0] u, logic [IN_W-1:0] p,
                                                 logic [IN_W-1:0] n, logic [IN_W-1:0] eu,
                                                 logic [IN_W-1:0] ep, logic [IN_W-1:0] en);
        t_bin_result  r;
        logic [127:0] sum;
        logic [63:0]  bg;
        logic [63:0]  err_root;
        r = '0;
        if (p == '0 || n == '0) begin
            r.sub_count = OUT_W'(u);
            r.sub_error = OUT_W'(eu);
            r.passed    = 1'b1;
            return r;
        end
        bg = root_floor(128'(p) * 128'(n) * 128'd16);
        r.sub_count = OUT_W'({32'd0, u} - bg);
        if (u != '0) begin
            sum = 128'(eu) * 128'(eu)
                + (128'(ep) * 128'(ep) * 128'(n) * 128'd4) / 128'(p)
                + (128'(en) * 128'(en) * 128'(p) * 128'd4) / 128'(n);
            err_root = root_floor(sum);
            if (err_root > 64'(ERR_MAX)) begin
                r.sub_error = ERR_MAX;
                r.sat       = 1'b1;
            end else begin
                r.sub_error = OUT_W'(err_root);
            end
        end
        return r;
    endfunction

    // Skewed field value: zero, one, full scale, small or fully random.
    function automatic logic [IN_W-1:0] draw_field();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3, 4: return 32'($urandom_range(0, 32'h00FF_FFFF));
            default: return $urandom();
        endcase
    endfunction

    // One bin transfer: optional gap, then hold the payload until accepted.
    task automatic send_bin(logic [IN_W-1:0] u, logic [IN_W-1:0] p, logic [IN_W-1:0] n,
                            logic [IN_W-1:0] eu, logic [IN_W-1:0] ep, logic [IN_W-1:0] en,
                            bit typed, t_bin_result typed_res);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_count_unlike <= u;
        i_count_pos    <= p;
        i_count_neg    <= n;
        i_error_unlike <= eu;
        i_error_pos    <= ep;
        i_error_neg    <= en;
        i_valid        <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        pending_bins.push_back(typed ? typed_res : subtract_bin(u, p, n, eu, ep, en));
    endtask

    // Stimulus: directed table, then random bins.
    initial begin
        t_bin_row    rows[$];
        t_bin_row    row;
        t_bin_result none;
        int          waited;
        none = '0;

        // The pass-through rows and the first zero-unlike row carry typed results.
        row = '{default: '0};
        row.typed = 1'b1; row.res = '{36'sd0, 36'd0, 1'b1, 1'b0};
        rows.push_back(row);
        row = '{u: '1, p: '0, n: '1, eu: '1, ep: '1, en: '1, typed: 1'b1,
                res: '{36'sh0_FFFF_FFFF, 36'h0_FFFF_FFFF, 1'b1, 1'b0}};
        rows.push_back(row);
        row = '{u: 32'h1234_5678, p: '1, n: '0, eu: 32'h0000_ABCD, ep: '1, en: '1,
                typed: 1'b1, res: '{36'sh0_1234_5678, 36'h0_0000_ABCD, 1'b1, 1'b0}};
        rows.push_back(row);
        row = '{u: '0, p: 32'h1_0000, n: 32'h1_0000, eu: '1, ep: '1, en: '1,
                typed: 1'b1, res: '{-36'sd262144, 36'd0, 1'b0, 1'b0}};
        rows.push_back(row);
        row = '{u: '1, p: 32'd1, n: '1, eu: '1, ep: '1, en: '1, typed: 1'b0, res: none};
        rows.push_back(row);
        row = '{u: 32'd1, p: '1, n: 32'd1, eu: '0, ep: '0, en: '1, typed: 1'b0, res: none};
        rows.push_back(row);
        row = '{u: '1, p: '1, n: '1, eu: '1, ep: '1, en: '1, typed: 1'b0, res: none};
        rows.push_back(row);
        row = '{u: 32'd1, p: 32'd1, n: 32'd1, eu: 32'd1, ep: 32'd1, en: 32'd1,
                typed: 1'b0, res: none};
        rows.push_back(row);
        row = '{u: '0, p: '1, n: '1, eu: '1, ep: '1, en: '1, typed: 1'b0, res: none};
        rows.push_back(row);
        row = '{u: 32'h0040_0000, p: 32'h0010_0000, n: 32'h0009_0000, eu: 32'h0002_0000,
                ep: 32'h0001_0000, en: 32'h0000_C000, typed: 1'b0, res: none};
        rows.push_back(row);
        row = '{u: 32'hAAAA_AAAA, p: 32'h5555_5555, n: 32'hAAAA_AAAA, eu: 32'h5555_5555,
                ep: 32'hAAAA_AAAA, en: 32'h5555_5555, typed: 1'b0, res: none};
        rows.push_back(row);
        row = '{u: '1, p: 32'd1, n: 32'd1, eu: '1, ep: '0, en: '0, typed: 1'b0, res: none};
        rows.push_back(row);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_bin(rows[k].u, rows[k].p, rows[k].n, rows[k].eu, rows[k].ep,
                     rows[k].en, rows[k].typed, rows[k].res);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            // A stretch without gaps or stalls.
            calm = (k >= 200 && k < 260);
            // Hold off once until the pipeline has drained completely.
            if (k == 100) begin
                i_valid <= 1'b0;
                wait (pending_bins.size() == 0);
                @(posedge i_clk);
            end
            send_bin(draw_field(), draw_field(), draw_field(), draw_field(),
                     draw_field(), draw_field(), 1'b0, none);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        waited = 0;
        while (pending_bins.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && pending_bins.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver: a random stall before each result transfer.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 18);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do begin
                @(posedge i_clk);
            end while (!o_valid);
        end
    end

    // Result check against the oldest prediction.
    always @(posedge i_clk) begin
        t_bin_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bins.size() == 0) begin
                $display("%0t: result with nothing expected: count %h error %h", $time,
                         o_sub_count, o_sub_error);
                mismatches++;
            end else begin
                want = pending_bins.pop_front();
                if (o_sub_count !== want.sub_count) begin
                    $display("%0t: sub_count expected %h actual %h", $time,
                             want.sub_count, o_sub_count);
                    mismatches++;
                end
                if (o_sub_error !== want.sub_error) begin
                    $display("%0t: sub_error expected %h actual %h", $time,
                             want.sub_error, o_sub_error);
                    mismatches++;
                end
                if (o_passed_through !== want.passed) begin
                    $display("%0t: passed_through expected %b actual %b", $time,
                             want.passed, o_passed_through);
                    mismatches++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.sat, o_saturated);
                    mismatches++;
                end
            end
        end
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
